FILE: rtl/core/rbuf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbuf_pkg: shared types and codes of the rollback union-find block
// Request and response payloads, status codes, mode codes and the states
// of the control sequencer.
// ----------------------------------------------------------------------------
package rbuf_pkg;

  // Fixed field widths of the request and response payloads
  localparam int unsigned NodeW  = 10;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned CountW = 11;

  // Value of node_count after reset
  localparam logic [CountW-1:0] CountReset = 11'd1024;

  // Request modes
  localparam logic ModeUnion = 1'b0;
  localparam logic ModeUndo  = 1'b1;

  // Response status codes
  typedef enum logic [2:0] {
    ST_MERGED = 3'd0,
    ST_SAME   = 3'd1,
    ST_UNDONE = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  // Control sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WALK_A,
    S_WALK_B,
    S_MERGE,
    S_UNDO_REC,
    S_UNDO_CH,
    S_UNDO_KEEP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             mode;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic             all_connected;
    logic [NodeW-1:0] root;
    logic [SizeW-1:0] set_size;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/rbuf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbuf_if: request and response channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rbuf_req_if;
  logic          valid;
  logic          ready;
  rbuf_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbuf_rsp_if;
  logic          valid;
  logic          ready;
  rbuf_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rbuf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbuf_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rbuf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned WIDTH = 25
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/rbuf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbuf_ctrl: union-find sequencer
// Walks parent links through the node RAM, merges roots by rank, pushes
// and pops undo records in the stack RAM, and builds one response per
// request. Also runs the clearing pass of the node RAM after reset.
// ----------------------------------------------------------------------------
module rbuf_ctrl #(
  parameter int unsigned NODES = 1024,
  parameter int unsigned IW    = 10,
  parameter int unsigned RW    = 4,
  parameter int unsigned SW    = 11,
  parameter int unsigned SAW   = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [rbuf_pkg::CountW-1:0]       node_count_i,
  rbuf_req_if.sink                               req_i,
  // result handoff to the output register
  output logic                                   res_valid_o,
  output rbuf_pkg::rsp_t                         res_o,
  input  wire logic                              res_take_i,
  // node RAM: {parent, rank, size}
  output logic                                   n_we_o,
  output logic [IW-1:0]                          n_waddr_o,
  output logic [IW+RW+SW-1:0]                    n_wdata_o,
  output logic                                   n_re_o,
  output logic [IW-1:0]                          n_raddr_o,
  input  wire logic [IW+RW+SW-1:0]               n_rdata_i,
  // stack RAM: {child, tie, size}
  output logic                                   s_we_o,
  output logic [SAW-1:0]                         s_waddr_o,
  output logic [IW+1+SW-1:0]                     s_wdata_o,
  output logic                                   s_re_o,
  output logic [SAW-1:0]                         s_raddr_o,
  input  wire logic [IW+1+SW-1:0]                s_rdata_i
);

  localparam int unsigned CW = (SW > rbuf_pkg::CountW) ? SW : rbuf_pkg::CountW;

  rbuf_pkg::state_e state_q, state_d;

  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] top_q, top_d;

  logic                        mode_q, mode_d;
  logic [rbuf_pkg::NodeW-1:0]  a_q, a_d, b_q, b_d;
  logic [IW-1:0]               cur_q, cur_d;
  logic [IW-1:0]               ra_q, ra_d;
  logic [RW-1:0]               rank_a_q, rank_a_d;
  logic [SW-1:0]               size_a_q, size_a_d;
  logic [IW-1:0]               keep_q, keep_d;
  logic [RW-1:0]               keep_rank_q, keep_rank_d;
  logic [SW-1:0]               sum_q, sum_d;
  logic [IW-1:0]               ch_q, ch_d;
  logic                        tie_q, tie_d;
  logic [SW-1:0]               rsize_q, rsize_d;
  rbuf_pkg::rsp_t              res_q, res_d;

  // Effective node count, clamped to NODES
  logic [CW-1:0] eff_n;
  assign eff_n = (CW'(node_count_i) > CW'(NODES)) ? CW'(NODES) : CW'(node_count_i);

  // Decoded node RAM word
  logic [IW-1:0] rd_parent;
  logic [RW-1:0] rd_rank;
  logic [SW-1:0] rd_size;
  assign rd_parent = n_rdata_i[IW+RW+SW-1 -: IW];
  assign rd_rank   = n_rdata_i[SW +: RW];
  assign rd_size   = n_rdata_i[SW-1:0];

  // Decoded stack record
  logic [IW-1:0] st_child;
  logic          st_tie;
  logic [SW-1:0] st_size;
  assign st_child = s_rdata_i[IW+1+SW-1 -: IW];
  assign st_tie   = s_rdata_i[SW];
  assign st_size  = s_rdata_i[SW-1:0];

  logic at_root;
  logic range_bad;
  logic swap;
  logic tie_w;
  logic [IW-1:0] keep_w, kid_w;
  logic [RW-1:0] keep_rank_w, kid_rank_w;
  logic [SW-1:0] keep_size_w, kid_size_w;
  logic [RW-1:0] un_rank;
  logic [SW-1:0] un_size;

  assign at_root   = (rd_parent == cur_q);
  assign range_bad = (CW'(a_q) >= eff_n) || (CW'(b_q) >= eff_n);

  // Order the two roots by rank; root of node_b goes under on a tie
  assign swap        = (rank_a_q < rd_rank);
  assign keep_w      = swap ? cur_q : ra_q;
  assign kid_w       = swap ? ra_q : cur_q;
  assign keep_rank_w = swap ? rd_rank : rank_a_q;
  assign kid_rank_w  = swap ? rank_a_q : rd_rank;
  assign keep_size_w = swap ? rd_size : size_a_q;
  assign kid_size_w  = swap ? size_a_q : rd_size;
  assign tie_w       = (rank_a_q == rd_rank);

  assign un_rank = rd_rank - RW'(tie_q);
  assign un_size = rd_size - rsize_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbuf_pkg::S_CLEAR: begin
        if (clr_q == IW'(NODES - 1)) begin
          state_d = rbuf_pkg::S_IDLE;
        end
      end
      rbuf_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = rbuf_pkg::S_DISPATCH;
        end
      end
      rbuf_pkg::S_DISPATCH: begin
        if (mode_q == rbuf_pkg::ModeUndo) begin
          state_d = (top_q == '0) ? rbuf_pkg::S_DONE : rbuf_pkg::S_UNDO_REC;
        end else begin
          state_d = range_bad ? rbuf_pkg::S_DONE : rbuf_pkg::S_WALK_A;
        end
      end
      rbuf_pkg::S_WALK_A: begin
        if (at_root) begin
          state_d = rbuf_pkg::S_WALK_B;
        end
      end
      rbuf_pkg::S_WALK_B: begin
        if (at_root) begin
          state_d = (cur_q == ra_q) ? rbuf_pkg::S_DONE : rbuf_pkg::S_MERGE;
        end
      end
      rbuf_pkg::S_MERGE:     state_d = rbuf_pkg::S_DONE;
      rbuf_pkg::S_UNDO_REC:  state_d = rbuf_pkg::S_UNDO_CH;
      rbuf_pkg::S_UNDO_CH:   state_d = rbuf_pkg::S_UNDO_KEEP;
      rbuf_pkg::S_UNDO_KEEP: state_d = rbuf_pkg::S_DONE;
      rbuf_pkg::S_DONE: begin
        if (res_take_i) begin
          state_d = rbuf_pkg::S_IDLE;
        end
      end
      default: state_d = rbuf_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_d       = clr_q;
    top_d       = top_q;
    mode_d      = mode_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    rank_a_d    = rank_a_q;
    size_a_d    = size_a_q;
    keep_d      = keep_q;
    keep_rank_d = keep_rank_q;
    sum_d       = sum_q;
    ch_d        = ch_q;
    tie_d       = tie_q;
    rsize_d     = rsize_q;
    res_d       = res_q;
    req_i.ready = 1'b0;
    res_valid_o = 1'b0;
    n_we_o      = 1'b0;
    n_waddr_o   = '0;
    n_wdata_o   = '0;
    n_re_o      = 1'b0;
    n_raddr_o   = '0;
    s_we_o      = 1'b0;
    s_waddr_o   = '0;
    s_wdata_o   = '0;
    s_re_o      = 1'b0;
    s_raddr_o   = '0;

    case (state_q)
      // Reset each node to its own root, rank 1, size 1
      rbuf_pkg::S_CLEAR: begin
        n_we_o    = 1'b1;
        n_waddr_o = clr_q;
        n_wdata_o = {clr_q, RW'(1), SW'(1)};
        clr_d     = clr_q + IW'(1);
      end

      // Take a request
      rbuf_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          mode_d = req_i.data.mode;
          a_d    = req_i.data.node_a;
          b_d    = req_i.data.node_b;
        end
      end

      // Check the request and start the first read
      rbuf_pkg::S_DISPATCH: begin
        if (mode_q == rbuf_pkg::ModeUndo) begin
          if (top_q == '0) begin
            res_d = '{status: rbuf_pkg::ST_EMPTY, all_connected: 1'b0,
                      root: '0, set_size: '0};
          end else begin
            s_re_o    = 1'b1;
            s_raddr_o = SAW'(top_q - IW'(1));
          end
        end else if (range_bad) begin
          res_d = '{status: rbuf_pkg::ST_RANGE, all_connected: 1'b0,
                    root: '0, set_size: '0};
        end else begin
          n_re_o    = 1'b1;
          n_raddr_o = IW'(a_q);
          cur_d     = IW'(a_q);
        end
      end

      // Follow links from node_a; at the root start on node_b
      rbuf_pkg::S_WALK_A: begin
        n_re_o = 1'b1;
        if (at_root) begin
          ra_d      = cur_q;
          rank_a_d  = rd_rank;
          size_a_d  = rd_size;
          n_raddr_o = IW'(b_q);
          cur_d     = IW'(b_q);
        end else begin
          n_raddr_o = rd_parent;
          cur_d     = rd_parent;
        end
      end

      // Follow links from node_b; at the root report a shared set or hang the lower-rank root
      rbuf_pkg::S_WALK_B: begin
        if (!at_root) begin
          n_re_o    = 1'b1;
          n_raddr_o = rd_parent;
          cur_d     = rd_parent;
        end else if (cur_q == ra_q) begin
          res_d = '{status: rbuf_pkg::ST_SAME,
                    all_connected: (CW'(size_a_q) == eff_n),
                    root: rbuf_pkg::NodeW'(ra_q),
                    set_size: rbuf_pkg::SizeW'(size_a_q)};
        end else begin
          if (top_q < IW'(NODES - 1)) begin
            s_we_o    = 1'b1;
            s_waddr_o = SAW'(top_q);
            s_wdata_o = {kid_w, tie_w, kid_size_w};
            top_d     = top_q + IW'(1);
          end
          n_we_o      = 1'b1;
          n_waddr_o   = kid_w;
          n_wdata_o   = {keep_w, kid_rank_w, kid_size_w};
          keep_d      = keep_w;
          keep_rank_d = keep_rank_w + RW'(tie_w);
          sum_d       = keep_size_w + kid_size_w;
        end
      end

      // Write back the surviving root
      rbuf_pkg::S_MERGE: begin
        n_we_o    = 1'b1;
        n_waddr_o = keep_q;
        n_wdata_o = {keep_q, keep_rank_q, sum_q};
        res_d = '{status: rbuf_pkg::ST_MERGED,
                  all_connected: (CW'(sum_q) == eff_n),
                  root: rbuf_pkg::NodeW'(keep_q),
                  set_size: rbuf_pkg::SizeW'(sum_q)};
      end

      // Pop the record and read the detached root
      rbuf_pkg::S_UNDO_REC: begin
        ch_d      = st_child;
        tie_d     = st_tie;
        rsize_d   = st_size;
        top_d     = top_q - IW'(1);
        n_re_o    = 1'b1;
        n_raddr_o = st_child;
      end

      // Detach the child root and read its former parent
      rbuf_pkg::S_UNDO_CH: begin
        n_we_o    = 1'b1;
        n_waddr_o = ch_q;
        n_wdata_o = {ch_q, rd_rank, rd_size};
        size_a_d  = rd_size;
        keep_d    = rd_parent;
        n_re_o    = 1'b1;
        n_raddr_o = rd_parent;
      end

      // Restore rank and size of the root that kept its place
      rbuf_pkg::S_UNDO_KEEP: begin
        n_we_o    = 1'b1;
        n_waddr_o = keep_q;
        n_wdata_o = {keep_q, un_rank, un_size};
        res_d = '{status: rbuf_pkg::ST_UNDONE,
                  all_connected: (CW'(un_size) == eff_n) || (CW'(size_a_q) == eff_n),
                  root: rbuf_pkg::NodeW'(keep_q),
                  set_size: rbuf_pkg::SizeW'(un_size)};
      end

      // Offer the response to the output register
      rbuf_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end

      default: ;
    endcase
  end

  assign res_o = res_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbuf_pkg::S_CLEAR;
      clr_q   <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    a_q         <= a_d;
    b_q         <= b_d;
    cur_q       <= cur_d;
    ra_q        <= ra_d;
    rank_a_q    <= rank_a_d;
    size_a_q    <= size_a_d;
    keep_q      <= keep_d;
    keep_rank_q <= keep_rank_d;
    sum_q       <= sum_d;
    ch_q        <= ch_d;
    tie_q       <= tie_d;
    rsize_q     <= rsize_d;
    res_q       <= res_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/rollback_union_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rollback_union_find: disjoint-set store with union by rank and undo
// Node RAM of {parent, rank, size}, undo stack RAM, sequencer and a
// response register.
// ----------------------------------------------------------------------------
// One request at a time. A union walks the parent links from node_a and
// then from node_b to their roots (each walk at most log2(NODES) links, so
// 10 for 1024 nodes) through the single read port of the node RAM, one link
// per cycle, then writes back the surviving root; a union within one set
// skips that write. An undo pops a record, detaches the child root and
// restores the root that kept its place; a request that is flagged (range
// or empty stack) goes straight to its response. After reset a clearing
// pass sets every node to its own root before the first request is taken;
// node_count writes are taken during it. A finished response waits in the
// output register while the next request is already being processed.
// ----------------------------------------------------------------------------
module rollback_union_find #(
  parameter int unsigned NODES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rbuf_pkg::CountW-1:0] cfg_wdata_i,
  rbuf_req_if.sink                         req_i,
  rbuf_rsp_if.source                       rsp_o
);

  localparam int unsigned IW  = $clog2(NODES);
  localparam int unsigned RW  = $clog2($clog2(NODES) + 2);
  localparam int unsigned SW  = $clog2(NODES + 1);
  localparam int unsigned SAW = (NODES > 2) ? $clog2(NODES - 1) : 1;
  localparam int unsigned NWW = IW + RW + SW;
  localparam int unsigned SWW = IW + 1 + SW;

  logic [rbuf_pkg::CountW-1:0] node_count_q;

  logic           res_valid;
  rbuf_pkg::rsp_t res;
  logic           res_take;
  logic           rsp_valid_q;
  rbuf_pkg::rsp_t rsp_data_q;

  logic           n_we, n_re;
  logic [IW-1:0]  n_waddr, n_raddr;
  logic [NWW-1:0] n_wdata, n_rdata;
  logic           s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SWW-1:0] s_wdata, s_rdata;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= rbuf_pkg::CountReset;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  rbuf_ram #(
    .DEPTH (NODES),
    .AW    (IW),
    .WIDTH (NWW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  rbuf_ram #(
    .DEPTH (NODES - 1),
    .AW    (SAW),
    .WIDTH (SWW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rbuf_ctrl #(
    .NODES (NODES),
    .IW    (IW),
    .RW    (RW),
    .SW    (SW),
    .SAW   (SAW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .req_i        (req_i),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take),
    .n_we_o       (n_we),
    .n_waddr_o    (n_waddr),
    .n_wdata_o    (n_wdata),
    .n_re_o       (n_re),
    .n_raddr_o    (n_raddr),
    .n_rdata_i    (n_rdata),
    .s_we_o       (s_we),
    .s_waddr_o    (s_waddr),
    .s_wdata_o    (s_wdata),
    .s_re_o       (s_re),
    .s_raddr_o    (s_raddr),
    .s_rdata_i    (s_rdata)
  );

  // Load the response register when it is empty or being drained
  assign res_take = res_valid && (!rsp_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_take) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      rsp_data_q <= res;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

endmodule
`default_nettype wire
